// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge of clk while out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/csvft_pkg.sv -----
// Types and constants of the CSV field tokenizer.
package csvft_pkg;

  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COMMA = 8'd44;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 8;
  localparam int DELIM_REGS    = 4;
  localparam int OUT_LINE_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DELIM_CHAR_0     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELIM_CHAR_1     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELIM_CHAR_2     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELIM_CHAR_3     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELIM_COUNT      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_ROW_HEADER = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } csv_in_t;

  typedef struct packed {
    logic [7:0]               out_char;
    logic                     char_valid;
    logic                     field_end;
    logic                     row_end;
    logic                     header_field;
    logic                     unmatched_quote;
    logic [OUT_LINE_BITS-1:0] line_number;
  } csv_out_t;

endpackage

// ----- rtl/csv_field_tokenizer.sv -----
// CSV field tokenizer: splits a byte stream into field content beats and field-end beats.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one text byte per beat, or an
//   end-of-input beat. Output channel out_valid/out_stall/out_data carries either
//   one content byte of the current field or one field-end marker per beat.
//   A beat that is the LF of a CR LF pair, and an end-of-input beat at the start
//   of an empty row with balanced quotes, produce no output beat.
//   Configuration (delimiters, delimiter count, header mode) is written through
//   cfg_we/cfg_index/cfg_wdata while the block is idle; it takes effect at once.
// Timing:
//   One input beat per cycle while in_stall is low; each output beat appears in the
//   output register in the cycle after its input beat is accepted. The work per byte
//   is a handful of compares and flag updates plus the line counter increment, all
//   between the state registers and the output register. in_stall rises only while
//   the output register is full and the receiver stalls, so the block holds one beat
//   and then stalls the input for as long as the receiver stalls.
// Reset:
//   rst_n (synchronous) empties the output register, restores the field and row
//   state, sets the line counter to 1 and loads the default configuration.
`include "assert_macros.svh"

module csv_field_tokenizer #(
  parameter int DELIM_SLOTS = 4,
  parameter int LINE_BITS   = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  csvft_pkg::csv_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output csvft_pkg::csv_out_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [csvft_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [csvft_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  import csvft_pkg::*;

  // Configuration registers.
  logic [7:0]           delim_r [DELIM_SLOTS];
  logic [2:0]           delim_count_r;
  logic                 first_row_header_r;

  // Parser state.
  logic                 quote_parity_r, quote_parity_nxt;
  logic                 quote_seen_r, quote_seen_nxt;
  logic                 prev_quote_r, prev_quote_nxt;
  logic                 after_cr_r, after_cr_nxt;
  logic                 field_has_bytes_r, field_has_bytes_nxt;
  logic                 at_row_start_r, at_row_start_nxt;
  logic                 in_first_row_r, in_first_row_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  csv_out_t             out_data_r, out_data_nxt;

  logic                 in_accept;
  logic                 res_valid;
  csv_out_t             res;
  logic [7:0]           in_byte;
  logic                 is_break;
  logic                 is_quote;
  logic                 delim_hit;
  logic                 ends_field;
  logic                 hdr;
  logic [LINE_BITS-1:0] line_step;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_byte   = in_data.data_byte;
  assign is_break  = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign is_quote  = (in_byte == CH_QUOTE);
  assign hdr       = first_row_header_r && in_first_row_r;

  always_comb begin
    line_step = line_r;
    if (is_break && (line_r != {LINE_BITS{1'b1}})) begin
      line_step = line_r + LINE_BITS'(1);
    end
  end

  // Only slots below both the delimiter count and the slot count take part.
  always_comb begin
    delim_hit = 1'b0;
    for (int i = 0; i < DELIM_SLOTS; i++) begin
      if ((int'(delim_count_r) > i) && (delim_r[i] == in_byte)) begin
        delim_hit = 1'b1;
      end
    end
  end

  // A separator closes the field only outside quoting; a line break inside an
  // odd quote run is always content.
  assign ends_field = !(is_break && quote_parity_r) && !is_quote &&
                      (is_break || delim_hit) &&
                      (!quote_seen_r || (prev_quote_r && !quote_parity_r));

  always_comb begin
    quote_parity_nxt    = quote_parity_r;
    quote_seen_nxt      = quote_seen_r;
    prev_quote_nxt      = prev_quote_r;
    after_cr_nxt        = after_cr_r;
    field_has_bytes_nxt = field_has_bytes_r;
    at_row_start_nxt    = at_row_start_r;
    in_first_row_nxt    = in_first_row_r;
    line_nxt            = line_r;
    res_valid           = 1'b0;
    res                 = '0;
    res.line_number     = OUT_LINE_BITS'(line_r);

    if (in_data.end_of_input) begin
      if (quote_parity_r || field_has_bytes_r || !at_row_start_r) begin
        res_valid           = 1'b1;
        res.field_end       = 1'b1;
        res.row_end         = 1'b1;
        res.header_field    = hdr;
        res.unmatched_quote = quote_parity_r;
      end
      quote_parity_nxt    = 1'b0;
      quote_seen_nxt      = 1'b0;
      prev_quote_nxt      = 1'b0;
      after_cr_nxt        = 1'b0;
      field_has_bytes_nxt = 1'b0;
      at_row_start_nxt    = 1'b1;
      in_first_row_nxt    = 1'b1;
      line_nxt            = LINE_BITS'(1);
    end else if (after_cr_r && (in_byte == CH_LF)) begin
      // Second half of a CR LF pair.
      after_cr_nxt = 1'b0;
    end else begin
      after_cr_nxt    = (in_byte == CH_CR);
      line_nxt        = line_step;
      res_valid       = 1'b1;
      res.line_number = OUT_LINE_BITS'(line_step);
      if (is_quote) begin
        quote_parity_nxt = !quote_parity_r;
        quote_seen_nxt   = 1'b1;
      end
      if (ends_field) begin
        res.field_end       = 1'b1;
        res.row_end         = is_break;
        res.header_field    = hdr;
        quote_parity_nxt    = 1'b0;
        quote_seen_nxt      = 1'b0;
        prev_quote_nxt      = 1'b0;
        field_has_bytes_nxt = 1'b0;
        at_row_start_nxt    = is_break;
        if (is_break) begin
          in_first_row_nxt = 1'b0;
        end
      end else begin
        prev_quote_nxt      = is_quote;
        field_has_bytes_nxt = 1'b1;
        at_row_start_nxt    = 1'b0;
        res.char_valid      = 1'b1;
        res.out_char        = is_break ? CH_LF : in_byte;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_accept) begin
      out_valid_nxt = res_valid;
      out_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_parity_r    <= 1'b0;
      quote_seen_r      <= 1'b0;
      prev_quote_r      <= 1'b0;
      after_cr_r        <= 1'b0;
      field_has_bytes_r <= 1'b0;
      at_row_start_r    <= 1'b1;
      in_first_row_r    <= 1'b1;
      line_r            <= LINE_BITS'(1);
      out_valid_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        quote_parity_r    <= quote_parity_nxt;
        quote_seen_r      <= quote_seen_nxt;
        prev_quote_r      <= prev_quote_nxt;
        after_cr_r        <= after_cr_nxt;
        field_has_bytes_r <= field_has_bytes_nxt;
        at_row_start_r    <= at_row_start_nxt;
        in_first_row_r    <= in_first_row_nxt;
        line_r            <= line_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Configuration writes; delimiter registers without a slot are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DELIM_SLOTS; i++) begin
        delim_r[i] <= (i == 0) ? CH_COMMA : 8'd0;
      end
      delim_count_r      <= 3'd1;
      first_row_header_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_DELIM_CHAR_0, CFG_DELIM_CHAR_1, CFG_DELIM_CHAR_2, CFG_DELIM_CHAR_3: begin
          for (int i = 0; i < DELIM_SLOTS; i++) begin
            if (int'(cfg_index) == i) begin
              delim_r[i] <= cfg_wdata[7:0];
            end
          end
        end
        CFG_DELIM_COUNT: begin
          delim_count_r <= cfg_wdata[2:0];
        end
        CFG_FIRST_ROW_HEADER: begin
          first_row_header_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_CLK(a_stall_only_when_full, in_stall |-> out_valid_r,
    "input stalled with empty output register")
  `ASSERT_NEVER(a_char_and_end,
    out_valid_r && out_data_r.char_valid && out_data_r.field_end,
    "content beat also marked as field end")
  `ASSERT_CLK(a_unmatched_at_row_end,
    (out_valid_r && out_data_r.unmatched_quote) |->
      (out_data_r.field_end && out_data_r.row_end),
    "unmatched quote outside a final field end")
  `ASSERT_CLK(a_eoi_restores, (in_accept && in_data.end_of_input) |=>
    (at_row_start_r && in_first_row_r && !quote_parity_r && (line_r == LINE_BITS'(1))),
    "end of input did not restore parser state")

endmodule

// ----- test/csv_field_tokenizer_tb.sv -----
// Self-checking testbench for the CSV field tokenizer: directed text, then random CSV rows.
module csv_field_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csvft_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 112;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_7 = 3'd7;
  localparam logic [OUT_LINE_BITS-1:0] LINE_FULL = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  csv_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  csv_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  csv_field_tokenizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror of the configuration registers.
  logic [7:0] delim_tab [DELIM_REGS];
  logic [2:0] delim_n;
  logic       hdr_mode;

  // Mirror of the parser state.
  bit q_odd, q_any, last_was_quote, cr_pending, field_open, row_fresh, first_row;
  logic [OUT_LINE_BITS-1:0] line_count;

  csv_in_t  text_beats [$];
  csv_out_t expected_tokens [$];
  int failures = 0;
  int cycle_count = 0;
  int beats_in = 0;
  bit in_fire = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet;

  always @(posedge clk) cycle_count <= cycle_count + 1;
  assign quiet = ((cycle_count / 256) % 4) == 0;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void clear_field();
    q_odd = 1'b0;
    q_any = 1'b0;
    last_was_quote = 1'b0;
    field_open = 1'b0;
  endfunction

  function automatic void restart_text();
    clear_field();
    cr_pending = 1'b0;
    row_fresh = 1'b1;
    first_row = 1'b1;
    line_count = 1;
  endfunction

  function automatic bit is_delimiter(logic [7:0] ch);
    int lim;
    lim = (delim_n > DELIM_REGS) ? DELIM_REGS : delim_n;
    for (int i = 0; i < lim; i++) begin
      if (delim_tab[i] == ch) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the parser mirror by one beat; returns 1 if the beat yields a result.
  function automatic bit tokenize_beat(input csv_in_t beat, output csv_out_t res);
    logic [7:0] ch;
    bit hdr, brk, found;
    ch = beat.data_byte;
    hdr = hdr_mode && first_row;
    res = '0;
    if (beat.end_of_input) begin
      res.field_end = 1'b1;
      res.row_end = 1'b1;
      res.header_field = hdr;
      res.unmatched_quote = q_odd;
      res.line_number = line_count;
      found = q_odd || field_open || !row_fresh;
      restart_text();
      return found;
    end
    // The LF of a CR LF pair was already counted with the CR.
    if (cr_pending && ch == CH_LF) begin
      cr_pending = 1'b0;
      return 1'b0;
    end
    cr_pending = (ch == CH_CR);
    brk = (ch == CH_CR) || (ch == CH_LF);
    if (brk) begin
      if (line_count != LINE_FULL) line_count++;
      ch = CH_LF;
    end
    res.line_number = line_count;
    if (!(brk && q_odd)) begin
      if (ch == CH_QUOTE) begin
        q_odd = !q_odd;
        q_any = 1'b1;
      end else if (brk || is_delimiter(ch)) begin
        if (!q_any || (last_was_quote && !q_odd)) begin
          res.field_end = 1'b1;
          res.row_end = brk;
          res.header_field = hdr;
          clear_field();
          row_fresh = brk;
          if (brk) first_row = 1'b0;
          return 1'b1;
        end
      end
    end
    last_was_quote = (ch == CH_QUOTE);
    field_open = 1'b1;
    row_fresh = 1'b0;
    res.out_char = ch;
    res.char_valid = 1'b1;
    return 1'b1;
  endfunction

  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  // Result side is checked before the new input beat is predicted.
  always @(posedge clk) begin
    csv_out_t want, res;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("result beat with nothing expected: 0x%0h", out_data);
        failures++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("out_char", 32'(want.out_char), 32'(out_data.out_char));
        check_field("char_valid", 32'(want.char_valid), 32'(out_data.char_valid));
        check_field("field_end", 32'(want.field_end), 32'(out_data.field_end));
        check_field("row_end", 32'(want.row_end), 32'(out_data.row_end));
        check_field("header_field", 32'(want.header_field), 32'(out_data.header_field));
        check_field("unmatched_quote", 32'(want.unmatched_quote),
                    32'(out_data.unmatched_quote));
        check_field("line_number", want.line_number, out_data.line_number);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      beats_in++;
      if (tokenize_beat(in_data, res)) expected_tokens.insert(expected_tokens.size(), res);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (text_beats.size() > 0) begin
        in_data <= text_beats.pop_front();
        in_valid <= 1'b1;
        send_gap = idle_len(quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long hold-off lets the output register fill and back up the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_len(quiet);
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < DELIM_REGS) delim_tab[idx[1:0]] = val;
    else if (idx == CFG_DELIM_COUNT) delim_n = val[2:0];
    else if (idx == CFG_FIRST_ROW_HEADER) hdr_mode = val[0];
  endtask

  task automatic push_byte(logic [7:0] b);
    csv_in_t beat;
    beat.data_byte = b;
    beat.end_of_input = 1'b0;
    text_beats.insert(text_beats.size(), beat);
  endtask

  task automatic push_eoi();
    csv_in_t beat;
    beat.data_byte = 8'($urandom_range(0, 255));
    beat.end_of_input = 1'b1;
    text_beats.insert(text_beats.size(), beat);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_delim();
    int lim;
    lim = (delim_n > DELIM_REGS) ? DELIM_REGS : delim_n;
    if (lim == 0) return CH_COMMA;
    return delim_tab[$urandom_range(0, lim - 1)];
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(0, 255));
    end while (b == CH_QUOTE || b == CH_CR || b == CH_LF || is_delimiter(b));
    return b;
  endfunction

  task automatic push_break();
    case ($urandom_range(0, 2))
      0: push_byte(CH_CR);
      1: push_byte(CH_LF);
      default: begin
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
    endcase
  endtask

  task automatic push_field();
    int len;
    len = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) begin
      push_byte(CH_QUOTE);
      repeat (len) begin
        case ($urandom_range(0, 7))
          0: begin
            push_byte(CH_QUOTE);
            push_byte(CH_QUOTE);
          end
          1: push_byte(pick_delim());
          2: push_break();
          default: push_byte(plain_byte());
        endcase
      end
      push_byte(CH_QUOTE);
    end else begin
      repeat (len) push_byte(plain_byte());
    end
  endtask

  // Stray quotes, separators, random bytes and early ends of input that break the row structure.
  task automatic push_noise();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 5))
        0: push_byte(CH_QUOTE);
        1: push_byte(CH_CR);
        2: push_byte(CH_LF);
        3: push_byte(pick_delim());
        4: push_eoi();
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic queue_rows(int n_bytes);
    int stop_at, nf;
    stop_at = text_beats.size() + n_bytes;
    while (text_beats.size() < stop_at) begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        push_field();
        if (f < nf - 1) push_byte(pick_delim());
      end
      if ($urandom_range(0, 9) == 0) push_eoi();
      else push_break();
      if ($urandom_range(0, 9) == 0) push_noise();
      if ($urandom_range(0, 7) == 0) push_eoi();
    end
  endtask

  // Waits until all text is sent and every expected result has come back.
  task automatic settle();
    int waited;
    while (text_beats.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (expected_tokens.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      $error("%0d expected results never arrived", expected_tokens.size());
      failures++;
      expected_tokens.delete();
    end
  endtask

  function automatic logic [7:0] common_delim();
    case ($urandom_range(0, 4))
      0: return CH_COMMA;
      1: return 8'd59;
      2: return 8'd9;
      3: return 8'd124;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [2:0] cnt;
    delim_tab = '{CH_COMMA, 8'd0, 8'd0, 8'd0};
    delim_n = 3'd1;
    hdr_mode = 1'b1;
    restart_text();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Default setup: plain field, quoted field holding a delimiter, CR LF row end,
    // a line break inside quotes, an unmatched quote and an empty end of input.
    push_str("hi,");
    push_str("\"x,y\",");
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_QUOTE);
    push_byte(CH_CR);
    push_byte(CH_QUOTE);
    push_byte(CH_LF);
    push_byte(CH_QUOTE);
    push_eoi();
    push_eoi();
    settle();

    // Quote and CR as delimiters, byte extremes as delimiters, count past the slots.
    write_reg(CFG_DELIM_CHAR_0, CH_QUOTE);
    write_reg(CFG_DELIM_CHAR_1, CH_CR);
    write_reg(CFG_DELIM_CHAR_2, 8'hFF);
    write_reg(CFG_DELIM_CHAR_3, 8'h00);
    write_reg(CFG_DELIM_COUNT, 8'hFF);
    write_reg(CFG_FIRST_ROW_HEADER, 8'hFE);
    write_reg(CFG_SPARE_6, 8'($urandom_range(0, 255)));
    write_reg(CFG_SPARE_7, 8'($urandom_range(0, 255)));
    push_byte(8'h61);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(CH_QUOTE);
    push_byte(CH_QUOTE);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_eoi();
    settle();

    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < DELIM_REGS; i++) begin
        write_reg(CFG_DELIM_CHAR_0 + i[CFG_IDX_BITS-1:0],
                  (p == 3) ? (i[0] ? 8'hFF : 8'h00) : common_delim());
      end
      case (p)
        0: cnt = 3'd0;
        1: cnt = 3'd4;
        2: cnt = 3'd7;
        3: cnt = 3'd2;
        default: cnt = 3'($urandom_range(1, 4));
      endcase
      write_reg(CFG_DELIM_COUNT, {5'($urandom_range(0, 31)), cnt});
      write_reg(CFG_FIRST_ROW_HEADER, {7'($urandom_range(0, 127)), ~p[0]});
      queue_rows(PHASE_BYTES);
      settle();
    end

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
